// ===== sv/wdcs_pkg.sv =====
package wdcs_pkg;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [16:0] MAX_CHANNELS = 17'd65536;

    localparam logic [CFG_IDX_BITS-1:0] REG_FREQ_LOW  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FREQ_HIGH = 1'b1;

    typedef struct packed {
        logic [31:0]        chan_freq;
        logic signed [23:0] sample_a;
        logic signed [23:0] sample_b;
        logic               end_of_dump;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] mean_a;
        logic signed [23:0] mean_b;
        logic [23:0]        sdev_a;
        logic [23:0]        sdev_b;
        logic signed [23:0] min_a;
        logic signed [23:0] max_a;
        logic signed [23:0] min_b;
        logic signed [23:0] max_b;
        logic [16:0]        used_count;
        logic               empty_window;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_START,
        ST_MUL,
        ST_DIFF,
        ST_SQRT,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } t_state;

endpackage

// ===== sv/wdcs_mul.sv =====
// 32x32 multiplier with registered product
module wdcs_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end
    assign o_p = r_p;
endmodule

// ===== sv/windowed_dual_channel_stats_unit.sv =====
// windowed two-polarization channel statistics
// input channel: i_in_valid / o_in_ready carry one spectrum channel per transfer
// (frequency, two 24-bit samples, end-of-dump flag). a channel strictly inside
// (freq_low, freq_high) updates sum, sum of squares, min, max and count.
// an ordinary channel passes the accepting state, the compare/update state
// ST_SQA, then ST_SQB and ST_START, where the shared 32x32 multiplier squares are added.
// on end_of_dump one result transfer leaves on o_out_valid / i_out_ready:
// mean, floor sqrt of population variance, min, max per polarization, count.
// per polarization the end of a dump runs: multiplier steps forming n*sumsq
// and sum^2 from 32-bit partial products, a difference step, a restoring
// square root of 64 steps and two restoring divides (sum/n and root/n) of
// 64 steps each, one bit per cycle, then a switch state (ST_NEXT).
// o_out_valid is set from ST_OUT, which an empty window reaches straight from
// ST_START. o_in_ready is low while a channel or a dump result is worked on.
// the result waits in the output register while the receiver stalls; the
// next channel is taken the cycle after that result is transferred.
// config writes (i_cfg_we, i_cfg_idx, i_cfg_data) land immediately.
// reset (i_rst_n low, synchronous) clears the accumulators and sets the
// window to its widest, (0, 0xFFFF_FFFF).
module windowed_dual_channel_stats_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wdcs_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wdcs_pkg::t_out_item o_out
);

    // window registers
    logic [31:0] r_flo, r_fhi;

    // accumulators
    logic signed [39:0] r_sum_a, r_sum_b;
    logic [63:0]        r_sq_a, r_sq_b;
    logic signed [23:0] r_lo_a, r_hi_a, r_lo_b, r_hi_b;
    logic [16:0]        r_cnt;

    wdcs_pkg::t_state r_state, n_state;
    wdcs_pkg::t_in_item r_item;
    logic r_inwin;

    // dump-end working registers
    logic          r_pol;      // 0 = a, 1 = b
    logic [2:0]    r_mstep;    // partial product index
    logic [127:0]  r_acc;      // product accumulator
    logic [127:0]  r_nsq;      // n*sumsq
    logic [127:0]  r_rad;      // radicand
    logic [63:0]   r_root;
    logic [6:0]    r_bit;
    logic [1:0]    r_dphase;   // 0 = mean divide, 1 = sdev divide
    logic [63:0]   r_num, r_quo;
    logic [63:0]   r_rem;
    wdcs_pkg::t_out_item r_out;
    logic          r_ovalid;

    // multiplier operand select
    logic [31:0] m_a, m_b;
    logic [63:0] m_p;
    wdcs_mul u_mul (.i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_p(m_p));

    logic signed [39:0] cur_sum;
    logic [63:0]        cur_sq, mag;
    logic [63:0]        n64;
    assign cur_sum = r_pol ? r_sum_b : r_sum_a;
    assign cur_sq  = r_pol ? r_sq_b : r_sq_a;
    assign mag     = cur_sum[39] ? -64'(cur_sum) : 64'(cur_sum);
    assign n64     = 64'(r_cnt);

    // ST_SQA/ST_SQB: sample squares; step 0..3: n * sumsq partials, 4..7: mag * mag partials
    always_comb begin
        m_a = 32'd0;
        m_b = 32'd0;
        case (r_state)
            wdcs_pkg::ST_SQA: begin
                m_a = {8'd0, r_item.sample_a[23] ? 24'(-r_item.sample_a)
                                                 : 24'(r_item.sample_a)};
                m_b = m_a;
            end
            wdcs_pkg::ST_SQB: begin
                m_a = {8'd0, r_item.sample_b[23] ? 24'(-r_item.sample_b)
                                                 : 24'(r_item.sample_b)};
                m_b = m_a;
            end
            wdcs_pkg::ST_MUL: begin
                if (!r_mstep[2]) begin
                    m_a = r_mstep[1] ? n64[63:32] : n64[31:0];
                    m_b = r_mstep[0] ? cur_sq[63:32] : cur_sq[31:0];
                end else begin
                    m_a = r_mstep[1] ? mag[63:32] : mag[31:0];
                    m_b = r_mstep[0] ? mag[63:32] : mag[31:0];
                end
            end
            default: ;
        endcase
    end

    // square root trial: (root|bit)^2 <= rad via incremental form
    logic [63:0]  cand;
    logic [127:0] cand_sq;
    logic [127:0] r_rsq;       // root^2 so far
    logic [5:0]   bidx;
    assign bidx    = r_bit[5:0];
    assign cand    = r_root | (64'd1 << bidx);
    // (r + 2^k)^2 = r^2 + r*2^(k+1) + 2^(2k)
    assign cand_sq = r_rsq + ({64'd0, r_root} << (bidx + 7'd1))
                     + (128'd1 << {bidx, 1'b0});

    // restoring divide step
    logic [64:0] dtrial;
    assign dtrial = {r_rem, r_num[63]} - {1'b0, n64};

    logic accept_in;
    assign o_in_ready  = (r_state == wdcs_pkg::ST_IDLE) && !r_ovalid;
    assign accept_in   = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wdcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wdcs_pkg::ST_IDLE:  if (accept_in) n_state = wdcs_pkg::ST_SQA;
            wdcs_pkg::ST_SQA:   n_state = wdcs_pkg::ST_SQB;
            wdcs_pkg::ST_SQB:   n_state = wdcs_pkg::ST_START;
            wdcs_pkg::ST_START: begin
                // the count is still the one before this channel
                if (!r_item.end_of_dump) n_state = wdcs_pkg::ST_IDLE;
                else if (r_cnt == 17'd0 && !r_inwin) n_state = wdcs_pkg::ST_OUT;
                else n_state = wdcs_pkg::ST_MUL;
            end
            wdcs_pkg::ST_MUL:   if (r_mstep == 3'd7) n_state = wdcs_pkg::ST_DIFF;
            wdcs_pkg::ST_DIFF:  n_state = wdcs_pkg::ST_SQRT;
            wdcs_pkg::ST_SQRT:  if (r_bit == 7'd0) n_state = wdcs_pkg::ST_DIV;
            wdcs_pkg::ST_DIV:   if (r_bit == 7'd0 && r_dphase == 2'd1)
                                    n_state = wdcs_pkg::ST_NEXT;
            wdcs_pkg::ST_NEXT:  n_state = r_pol ? wdcs_pkg::ST_OUT : wdcs_pkg::ST_MUL;
            wdcs_pkg::ST_OUT:   n_state = wdcs_pkg::ST_IDLE;
            default:            n_state = wdcs_pkg::ST_IDLE;
        endcase
    end

    // product of the previous multiplier cycle, placed by its partial index
    logic [2:0]   r_pstep;
    logic         r_pvalid;
    logic [127:0] pshift;
    assign pshift = {64'd0, m_p} << ({5'd0, r_pstep[1]} * 7'd32 + {5'd0, r_pstep[0]} * 7'd32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flo    <= 32'd0;
            r_fhi    <= 32'hFFFF_FFFF;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_sq_a   <= '0;
            r_sq_b   <= '0;
            r_lo_a   <= '0;
            r_hi_a   <= '0;
            r_lo_b   <= '0;
            r_hi_b   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == wdcs_pkg::REG_FREQ_LOW) r_flo <= i_cfg_data;
                else r_fhi <= i_cfg_data;
            end
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            r_pvalid <= (r_state == wdcs_pkg::ST_MUL);
            r_pstep  <= r_mstep;

            case (r_state)
                wdcs_pkg::ST_IDLE: begin
                    if (accept_in) begin
                        r_item  <= i_in;
                        r_inwin <= (i_in.chan_freq > r_flo) && (i_in.chan_freq < r_fhi)
                                   && (r_cnt < wdcs_pkg::MAX_CHANNELS);
                    end
                end
                wdcs_pkg::ST_SQA: begin
                    if (r_inwin) begin
                        if (r_cnt == 17'd0) begin
                            r_lo_a <= r_item.sample_a;
                            r_hi_a <= r_item.sample_a;
                            r_lo_b <= r_item.sample_b;
                            r_hi_b <= r_item.sample_b;
                        end else begin
                            if (r_item.sample_a < r_lo_a) r_lo_a <= r_item.sample_a;
                            if (r_item.sample_a > r_hi_a) r_hi_a <= r_item.sample_a;
                            if (r_item.sample_b < r_lo_b) r_lo_b <= r_item.sample_b;
                            if (r_item.sample_b > r_hi_b) r_hi_b <= r_item.sample_b;
                        end
                        r_sum_a <= r_sum_a + 40'(r_item.sample_a);
                        r_sum_b <= r_sum_b + 40'(r_item.sample_b);
                    end
                end
                wdcs_pkg::ST_SQB: begin
                    if (r_inwin) r_sq_a <= r_sq_a + m_p;
                end
                wdcs_pkg::ST_START: begin
                    if (r_inwin) begin
                        r_sq_b <= r_sq_b + m_p;
                        r_cnt  <= r_cnt + 17'd1;
                    end
                    r_pol   <= 1'b0;
                    r_mstep <= 3'd0;
                    r_acc   <= '0;
                end
                wdcs_pkg::ST_MUL: begin
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep == 3'd4) begin
                        r_nsq <= r_acc + pshift;
                        r_acc <= '0;
                    end else if (r_pvalid) begin
                        r_acc <= r_acc + pshift;
                    end
                end
                wdcs_pkg::ST_DIFF: begin
                    r_rad   <= r_nsq - (r_acc + pshift);
                    r_root  <= '0;
                    r_rsq   <= '0;
                    r_bit   <= 7'd63;
                end
                wdcs_pkg::ST_SQRT: begin
                    if (cand_sq <= r_rad) begin
                        r_root <= cand;
                        r_rsq  <= cand_sq;
                    end
                    if (r_bit == 7'd0) begin
                        r_dphase <= 2'd0;
                        r_num    <= mag;
                        r_rem    <= '0;
                        r_quo    <= '0;
                        r_bit    <= 7'd63;
                    end else begin
                        r_bit <= r_bit - 7'd1;
                    end
                end
                wdcs_pkg::ST_DIV: begin
                    r_num <= {r_num[62:0], 1'b0};
                    if (!dtrial[64]) begin
                        r_rem <= dtrial[63:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_num[63]};
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    if (r_bit == 7'd0) begin
                        if (r_dphase == 2'd0) begin
                            if (!dtrial[64]) begin
                                if (r_pol) r_out.mean_b <= 24'(cur_sum[39] ? -{r_quo[62:0], 1'b1}
                                                             : {r_quo[62:0], 1'b1});
                                else       r_out.mean_a <= 24'(cur_sum[39] ? -{r_quo[62:0], 1'b1}
                                                             : {r_quo[62:0], 1'b1});
                            end else begin
                                if (r_pol) r_out.mean_b <= 24'(cur_sum[39] ? -{r_quo[62:0], 1'b0}
                                                             : {r_quo[62:0], 1'b0});
                                else       r_out.mean_a <= 24'(cur_sum[39] ? -{r_quo[62:0], 1'b0}
                                                             : {r_quo[62:0], 1'b0});
                            end
                            r_dphase <= 2'd1;
                            r_num    <= r_root;
                            r_rem    <= '0;
                            r_quo    <= '0;
                            r_bit    <= 7'd63;
                        end else begin
                            if (r_pol) r_out.sdev_b <= 24'({r_quo[62:0], !dtrial[64]});
                            else       r_out.sdev_a <= 24'({r_quo[62:0], !dtrial[64]});
                        end
                    end else begin
                        r_bit <= r_bit - 7'd1;
                    end
                end
                wdcs_pkg::ST_NEXT: begin
                    r_pol   <= 1'b1;
                    r_mstep <= 3'd0;
                    r_acc   <= '0;
                end
                wdcs_pkg::ST_OUT: begin
                    if (r_cnt == 17'd0) begin
                        // all fields zero, empty flag in the lowest bit
                        r_out <= {{($bits(wdcs_pkg::t_out_item) - 1){1'b0}}, 1'b1};
                    end else begin
                        r_out.min_a <= r_lo_a;
                        r_out.max_a <= r_hi_a;
                        r_out.min_b <= r_lo_b;
                        r_out.max_b <= r_hi_b;
                        r_out.used_count <= r_cnt;
                        r_out.empty_window <= 1'b0;
                    end
                    r_ovalid <= 1'b1;
                    r_sum_a <= '0;
                    r_sum_b <= '0;
                    r_sq_a  <= '0;
                    r_sq_b  <= '0;
                    r_lo_a  <= '0;
                    r_hi_a  <= '0;
                    r_lo_b  <= '0;
                    r_hi_b  <= '0;
                    r_cnt   <= '0;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_ready_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != wdcs_pkg::ST_IDLE) |-> !o_in_ready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.empty_window) |-> (o_out.used_count == 17'd0))
        else $error("empty result with count");
`endif

endmodule
